// ===== rtl/sma_pkg.sv =====
package sma_pkg;

	localparam int WORD_W = 64;
	localparam int DEFAULT_ENTRIES = 256;

	localparam logic [4:0] M_PUSH = 5'd0;
	localparam logic [4:0] M_ADD  = 5'd1;
	localparam logic [4:0] M_SUB  = 5'd2;
	localparam logic [4:0] M_MUL  = 5'd3;
	localparam logic [4:0] M_DIV  = 5'd4;
	localparam logic [4:0] M_REM  = 5'd5;
	localparam logic [4:0] M_MOD  = 5'd6;
	localparam logic [4:0] M_GT   = 5'd7;
	localparam logic [4:0] M_LT   = 5'd8;
	localparam logic [4:0] M_EQ   = 5'd9;
	localparam logic [4:0] M_NEQ  = 5'd10;
	localparam logic [4:0] M_DOT  = 5'd11;
	localparam logic [4:0] M_EMIT = 5'd12;
	localparam logic [4:0] M_DUP  = 5'd13;
	localparam logic [4:0] M_DROP = 5'd14;
	localparam logic [4:0] M_SWAP = 5'd15;
	localparam logic [4:0] M_OVER = 5'd16;
	localparam logic [4:0] M_ROT  = 5'd17;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MD_MUL = 2'd0,
		MD_DIV = 2'd1,
		MD_REM = 2'd2,
		MD_MOD = 2'd3
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_req_t;

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_RUN,
		MS_FIN
	} md_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CAP,
		S_EXEC,
		S_MD,
		S_WRITE,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [4:0]               mode;
		logic signed [WORD_W-1:0] literal;
	} cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic                     print_valid;
		logic                     print_is_char;
		logic signed [WORD_W-1:0] print_value;
		logic [8:0]               depth_now;
	} rsp_t;

endpackage

// ===== rtl/sma_stack_mem.sv =====
module sma_stack_mem import sma_pkg::*; #(
	parameter int ENTRIES = DEFAULT_ENTRIES,
	parameter int AW = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/sma_muldiv.sv =====
module sma_muldiv import sma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  md_req_t           req,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic              done,
	output logic [WORD_W-1:0] res
);

	md_state_t state_q, state_d;
	md_op_t op_q;
	logic [5:0] cnt_q;
	logic [WORD_W-1:0] acc_q, x_q, y_q, res_q;
	logic an_q, bn_q, done_q;
	logic [WORD_W:0] shifted, diff;
	logic [WORD_W-1:0] rm;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MS_IDLE: if (req.start) state_d = MS_RUN;
			MS_RUN:  if (cnt_q == 6'd0) state_d = MS_FIN;
			MS_FIN:  state_d = MS_IDLE;
			default: state_d = MS_IDLE;
		endcase
	end

	// one quotient bit per cycle
	assign shifted = {acc_q, x_q[WORD_W-1]};
	assign diff = shifted - {1'b0, y_q};
	assign rm = an_q ? (~acc_q + 1'b1) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == MS_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				op_q <= req.op;
				cnt_q <= 6'd63;
				acc_q <= '0;
				an_q <= a[WORD_W-1];
				bn_q <= b[WORD_W-1];
				if (req.op == MD_MUL) begin
					x_q <= a;
					y_q <= b;
				end else begin
					x_q <= a[WORD_W-1] ? (~a + 1'b1) : a;
					y_q <= b[WORD_W-1] ? (~b + 1'b1) : b;
				end
			end
			MS_RUN: begin
				cnt_q <= cnt_q - 6'd1;
				if (op_q == MD_MUL) begin
					if (y_q[0]) acc_q <= acc_q + x_q;
					x_q <= {x_q[WORD_W-2:0], 1'b0};
					y_q <= {1'b0, y_q[WORD_W-1:1]};
				end else begin
					if (!diff[WORD_W]) begin
						acc_q <= diff[WORD_W-1:0];
					end else begin
						acc_q <= shifted[WORD_W-1:0];
					end
					x_q <= {x_q[WORD_W-2:0], ~diff[WORD_W]};
				end
			end
			MS_FIN: begin
				case (op_q)
					MD_MUL: res_q <= acc_q;
					MD_DIV: res_q <= (an_q ^ bn_q) ? (~x_q + 1'b1) : x_q;
					MD_REM: res_q <= rm;
					default: begin
						// floored: shift a nonzero remainder toward the divisor's sign
						if (acc_q != '0 && an_q != bn_q) begin
							res_q <= an_q ? (y_q - acc_q) : (acc_q - y_q);
						end else begin
							res_q <= rm;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== rtl/stack_machine_alu_top.sv =====
// stack machine alu: runs one stack primitive per item on a signed 64-bit data stack.
// command channel cmd_valid / cmd_stall / cmd carries mode and literal; an item is
// taken on a clock edge with cmd_valid high and cmd_stall low.
// response channel rsp_valid / rsp_stall / rsp returns one item per command with
// status, print fields and the stack depth after the command.
// cmd_stall is high while a command is in work; the next command is taken the cycle
// after the response is loaded, even while that response still waits downstream.
// from accept to rsp_valid, each stack entry read passes a read and a capture state
// (up to 3 entries), then the execute state, a write state per entry written (up to 3),
// then the done state; mul, div, rem and mod wait on the shared shift-add/subtract unit,
// which runs one bit per cycle. underflow, overflow and unused modes go straight from
// accept to the done state; a zero divisor shows up after both operands are read;
// errors leave the stack as it was. the stack memory has one read and one write port;
// operands are fetched one entry at a time, which sets the cost of each read.
// a stalled response holds in its output register; a finished command waits for
// it to drain before its response is loaded.
// reset clears the depth to zero and drops any pending response; memory contents
// are not cleared, only entries below the depth are ever read.
module stack_machine_alu_top import sma_pkg::*; #(
	parameter int STACK_ENTRIES = DEFAULT_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(STACK_ENTRIES);
	localparam int DW = $clog2(STACK_ENTRIES + 1);
	localparam logic [DW-1:0] FULL = DW'(STACK_ENTRIES);

	seq_state_t state_q, state_d;
	logic [DW-1:0] depth_q, nd_q, wbase_q;
	logic [4:0] mode_q;
	logic [WORD_W-1:0] lit_q;
	logic [1:0] need_q, rcnt_q, wcnt_q, wn_q;
	logic [WORD_W-1:0] opnd_q [3];
	logic [WORD_W-1:0] wval_q [3];
	status_t status_q;
	logic pv_q, pc_q;
	logic [WORD_W-1:0] pval_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [1:0] dec_need;
	logic dec_grow, dec_unused;
	status_t dec_status;

	logic [1:0] ex_wn;
	logic [DW-1:0] ex_wbase, ex_nd;
	logic [WORD_W-1:0] ex_w0, ex_w1, ex_w2, ex_r;
	logic ex_md, ex_divz;
	md_op_t ex_op;

	logic accept, load_rsp;
	logic wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [WORD_W-1:0] wr_data, rd_data;
	md_req_t md_req;
	logic md_done;
	logic [WORD_W-1:0] md_res;

	sma_stack_mem #(.ENTRIES(STACK_ENTRIES), .AW(AW)) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	sma_muldiv u_md (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.a(opnd_q[0]),
		.b(opnd_q[1]),
		.done(md_done),
		.res(md_res)
	);

	// operand count and growth per mode
	always_comb begin
		dec_need = 2'd0;
		dec_grow = 1'b0;
		dec_unused = 1'b0;
		case (cmd.mode) inside
			M_PUSH: dec_grow = 1'b1;
			[M_ADD:M_NEQ], M_SWAP: dec_need = 2'd2;
			M_DOT, M_EMIT, M_DROP: dec_need = 2'd1;
			M_DUP: begin
				dec_need = 2'd1;
				dec_grow = 1'b1;
			end
			M_OVER: begin
				dec_need = 2'd2;
				dec_grow = 1'b1;
			end
			M_ROT: dec_need = 2'd3;
			default: dec_unused = 1'b1;
		endcase
		if (dec_unused) begin
			dec_status = ST_OK;
		end else if (depth_q < DW'(dec_need)) begin
			dec_status = ST_UNDER;
		end else if (dec_grow && depth_q >= FULL) begin
			dec_status = ST_OVER;
		end else begin
			dec_status = ST_OK;
		end
	end

	// result of the primitive once its operands are in
	always_comb begin
		ex_wn = 2'd0;
		ex_wbase = depth_q - DW'(2);
		ex_nd = depth_q - DW'(1);
		ex_w0 = opnd_q[0];
		ex_w1 = opnd_q[1];
		ex_w2 = opnd_q[2];
		ex_md = 1'b0;
		ex_divz = 1'b0;
		ex_op = MD_MUL;
		ex_r = '0;
		case (mode_q)
			M_ADD: ex_r = opnd_q[0] + opnd_q[1];
			M_SUB: ex_r = opnd_q[0] - opnd_q[1];
			M_GT:  ex_r = WORD_W'($signed(opnd_q[0]) > $signed(opnd_q[1]));
			M_LT:  ex_r = WORD_W'($signed(opnd_q[0]) < $signed(opnd_q[1]));
			M_EQ:  ex_r = WORD_W'(opnd_q[0] == opnd_q[1]);
			M_NEQ: ex_r = WORD_W'(opnd_q[0] != opnd_q[1]);
			default: ex_r = '0;
		endcase
		case (mode_q) inside
			M_PUSH: begin
				ex_wn = 2'd1;
				ex_wbase = depth_q;
				ex_nd = depth_q + DW'(1);
				ex_w0 = lit_q;
			end
			M_ADD, M_SUB, [M_GT:M_NEQ]: begin
				ex_wn = 2'd1;
				ex_w0 = ex_r;
			end
			M_MUL: begin
				ex_md = 1'b1;
				ex_op = MD_MUL;
			end
			[M_DIV:M_MOD]: begin
				if (opnd_q[1] == '0) begin
					ex_divz = 1'b1;
					ex_nd = depth_q;
				end else begin
					ex_md = 1'b1;
					ex_op = (mode_q == M_DIV) ? MD_DIV : ((mode_q == M_REM) ? MD_REM : MD_MOD);
				end
			end
			M_DUP: begin
				ex_wn = 2'd1;
				ex_wbase = depth_q;
				ex_nd = depth_q + DW'(1);
			end
			M_SWAP: begin
				ex_wn = 2'd2;
				ex_nd = depth_q;
			end
			M_OVER: begin
				ex_wn = 2'd1;
				ex_wbase = depth_q;
				ex_nd = depth_q + DW'(1);
				ex_w0 = opnd_q[1];
			end
			M_ROT: begin
				ex_wn = 2'd3;
				ex_wbase = depth_q - DW'(3);
				ex_nd = depth_q;
				ex_w0 = opnd_q[1];
				ex_w1 = opnd_q[0];
				ex_w2 = opnd_q[2];
			end
			default: ;
		endcase
	end

	assign accept = cmd_valid && (state_q == S_IDLE);
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (dec_unused || dec_status != ST_OK) state_d = S_DONE;
					else if (dec_need == 2'd0) state_d = S_EXEC;
					else state_d = S_READ;
				end
			end
			S_READ: state_d = S_CAP;
			S_CAP: state_d = (rcnt_q == need_q - 2'd1) ? S_EXEC : S_READ;
			S_EXEC: begin
				if (ex_md) state_d = S_MD;
				else if (ex_wn != 2'd0) state_d = S_WRITE;
				else state_d = S_DONE;
			end
			S_MD: if (md_done) state_d = S_WRITE;
			S_WRITE: if (wcnt_q == wn_q - 2'd1) state_d = S_DONE;
			S_DONE: if (load_rsp) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = (state_q != S_IDLE);
		rd_en = (state_q == S_READ);
		rd_addr = AW'(depth_q - DW'(1) - DW'(rcnt_q));
		wr_en = (state_q == S_WRITE);
		wr_addr = AW'(wbase_q + DW'(wcnt_q));
		wr_data = wval_q[wcnt_q];
		md_req.start = (state_q == S_EXEC) && ex_md;
		md_req.op = ex_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_rsp) depth_q <= nd_q;
			if (load_rsp) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cmd.mode;
			lit_q <= cmd.literal;
			need_q <= dec_need;
			rcnt_q <= 2'd0;
			wcnt_q <= 2'd0;
			status_q <= dec_status;
			pv_q <= 1'b0;
			pc_q <= 1'b0;
			pval_q <= '0;
			nd_q <= depth_q;
		end
		if (state_q == S_CAP) begin
			opnd_q[rcnt_q] <= rd_data;
			rcnt_q <= rcnt_q + 2'd1;
		end
		if (state_q == S_EXEC) begin
			wn_q <= ex_wn;
			wbase_q <= ex_wbase;
			nd_q <= ex_nd;
			wval_q[0] <= ex_w0;
			wval_q[1] <= ex_w1;
			wval_q[2] <= ex_w2;
			if (ex_divz) status_q <= ST_DIVZ;
			if (mode_q == M_DOT || mode_q == M_EMIT) begin
				pv_q <= 1'b1;
				pc_q <= (mode_q == M_EMIT);
				pval_q <= opnd_q[0];
			end
		end
		if (state_q == S_MD && md_done) begin
			wn_q <= 2'd1;
			wval_q[0] <= md_res;
		end
		if (state_q == S_WRITE) wcnt_q <= wcnt_q + 2'd1;
		if (load_rsp) begin
			rsp_q.status <= status_q;
			rsp_q.print_valid <= pv_q;
			rsp_q.print_is_char <= pc_q;
			rsp_q.print_value <= pval_q;
			rsp_q.depth_now <= 9'(nd_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= FULL) else $error("stack depth beyond capacity");
	a_md_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> state_q == S_MD) else $error("divider finished outside its wait");
	a_rsp_depth: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |=> rsp_valid && rsp.depth_now == 9'(depth_q))
		else $error("reported depth differs from stack depth");
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> status_q == ST_OK) else $error("stack written on error");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import sma_pkg::*;

	localparam int DEPTH_MAX = DEFAULT_ENTRIES;
	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [63:0] MOST_NEG = 64'sh8000_0000_0000_0000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	stack_machine_alu_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	cmd_t pending_cmds[$];
	rsp_t expected_rsps[$];
	logic signed [63:0] model_stack[DEPTH_MAX];
	int model_depth;
	int errors;
	int idle_cycles;
	bit quiet_tail;
	bit long_hold;
	int send_gap;
	int recv_gap;
	int hold_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic rsp_t execute_cmd(input cmd_t c);
		rsp_t r;
		int need;
		bit grow;
		logic signed [63:0] a, b, v, m;
		r = '0;
		need = 0;
		grow = 0;
		case (c.mode)
			M_PUSH: grow = 1;
			M_ADD, M_SUB, M_MUL, M_DIV, M_REM, M_MOD, M_GT, M_LT, M_EQ, M_NEQ: need = 2;
			M_DOT, M_EMIT, M_DROP: need = 1;
			M_DUP: begin need = 1; grow = 1; end
			M_SWAP: need = 2;
			M_OVER: begin need = 2; grow = 1; end
			M_ROT: need = 3;
			default: ;
		endcase
		if (c.mode > M_ROT) begin
			r.status = ST_OK;
		end else if (model_depth < need) begin
			r.status = ST_UNDER;
		end else if (grow && model_depth >= DEPTH_MAX) begin
			r.status = ST_OVER;
		end else begin
			case (c.mode)
				M_PUSH: begin
					model_stack[model_depth] = c.literal;
					model_depth++;
				end
				M_DOT, M_EMIT: begin
					r.print_valid = 1'b1;
					r.print_is_char = (c.mode == M_EMIT);
					r.print_value = model_stack[model_depth-1];
					model_depth--;
				end
				M_DUP: begin
					model_stack[model_depth] = model_stack[model_depth-1];
					model_depth++;
				end
				M_DROP: model_depth--;
				M_SWAP: begin
					v = model_stack[model_depth-1];
					model_stack[model_depth-1] = model_stack[model_depth-2];
					model_stack[model_depth-2] = v;
				end
				M_OVER: begin
					model_stack[model_depth] = model_stack[model_depth-2];
					model_depth++;
				end
				M_ROT: begin
					// c b a -> top a, then c, then b
					v = model_stack[model_depth-3];
					model_stack[model_depth-3] = model_stack[model_depth-2];
					model_stack[model_depth-2] = model_stack[model_depth-1];
					model_stack[model_depth-1] = v;
				end
				default: begin
					a = model_stack[model_depth-1];
					b = model_stack[model_depth-2];
					v = '0;
					if ((c.mode == M_DIV || c.mode == M_REM || c.mode == M_MOD) && b == 0) begin
						r.status = ST_DIVZ;
					end else begin
						case (c.mode)
							M_ADD: v = a + b;
							M_SUB: v = a - b;
							M_MUL: v = a * b;
							M_GT: v = (a > b);
							M_LT: v = (a < b);
							M_EQ: v = (a == b);
							M_NEQ: v = (a != b);
							default: begin
								if (a == MOST_NEG && b == -1) begin
									v = (c.mode == M_DIV) ? a : 64'sd0;
								end else if (c.mode == M_DIV) begin
									v = a / b;
								end else begin
									m = a % b;
									if (c.mode == M_MOD && m != 0 && ((m < 0) != (b < 0)))
										m = m + b;
									v = m;
								end
							end
						endcase
						model_depth--;
						model_stack[model_depth-1] = v;
					end
				end
			endcase
		end
		r.depth_now = model_depth[8:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_gap <= 0;
		end else if (!(cmd_valid && cmd_stall)) begin
			if (cmd_valid)
				expected_rsps.insert(expected_rsps.size(), execute_cmd(cmd));
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() > 0 && !(!quiet_tail && $urandom_range(0, 15) == 0)) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
				if (!quiet_tail && pending_cmds.size() > 0)
					send_gap <= $urandom_range(1, 17);
			end
		end
	end

	// receiver side stall and checker
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			recv_gap <= 0;
			hold_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					report("unexpected item", 128'(rsp), 128'(0));
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status)
						report("status", 128'(rsp.status), 128'(want.status));
					if (rsp.print_valid !== want.print_valid)
						report("print_valid", 128'(rsp.print_valid), 128'(want.print_valid));
					if (rsp.print_is_char !== want.print_is_char)
						report("print_is_char", 128'(rsp.print_is_char),
							128'(want.print_is_char));
					if (rsp.print_value !== want.print_value)
						report("print_value", 128'(rsp.print_value), 128'(want.print_value));
					if (rsp.depth_now !== want.depth_now)
						report("depth_now", 128'(rsp.depth_now), 128'(want.depth_now));
				end
			end
			if (long_hold && hold_count < 600) begin
				hold_count <= hold_count + 1;
				rsp_stall <= 1'b1;
			end else if (quiet_tail) begin
				rsp_stall <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 19) == 0) begin
				recv_gap <= $urandom_range(1, 17);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic signed [63:0] rand_word();
		logic signed [63:0] w;
		case ($urandom_range(0, 5))
			0: w = MOST_NEG;
			1: w = 64'sh7fff_ffff_ffff_ffff;
			2: w = $signed($urandom_range(0, 2)) - 1;
			3: w = $signed($urandom_range(0, 20)) - 10;
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	task automatic queue_cmd(input logic [4:0] mode, input logic signed [63:0] lit);
		cmd_t c;
		c.mode = mode;
		c.literal = lit;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || cmd_valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [4:0] op;
		int depth_guess;
		errors = 0;
		quiet_tail = 0;
		long_hold = 0;
		idle_cycles = 0;
		model_depth = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: underflow on empty, extremes, division corner cases
		queue_cmd(M_ADD, 0);
		queue_cmd(M_DOT, 0);
		queue_cmd(M_PUSH, -1);
		queue_cmd(M_PUSH, MOST_NEG);
		queue_cmd(M_DIV, 0);
		queue_cmd(M_PUSH, -1);
		queue_cmd(M_SWAP, 0);
		queue_cmd(M_REM, 0);
		queue_cmd(M_PUSH, 0);
		queue_cmd(M_SWAP, 0);
		queue_cmd(M_MOD, 0);
		queue_cmd(M_PUSH, -7);
		queue_cmd(M_PUSH, 64'sh7fff_ffff_ffff_ffff);
		queue_cmd(M_MOD, 0);
		queue_cmd(M_PUSH, 3);
		queue_cmd(M_OVER, 0);
		queue_cmd(M_ROT, 0);
		queue_cmd(M_MUL, 0);
		queue_cmd(M_GT, 0);
		queue_cmd(M_DUP, 0);
		queue_cmd(M_LT, 0);
		queue_cmd(M_EMIT, 0);
		queue_cmd(5'd31, -1);
		queue_cmd(M_DROP, 0);
		queue_cmd(M_DROP, 0);
		wait_drained();

		// fill to overflow while the receiver holds off
		long_hold = 1;
		for (int i = 0; i < DEPTH_MAX + 2; i++)
			queue_cmd(M_PUSH, rand_word());
		queue_cmd(M_DUP, 0);
		queue_cmd(M_OVER, 0);
		wait_drained();
		long_hold = 0;
		for (int i = 0; i < DEPTH_MAX; i++)
			queue_cmd(($urandom_range(0, 1) != 0) ? M_DOT : M_EMIT, 0);
		wait_drained();

		// random: keep the stack shallow so most ops succeed
		depth_guess = 0;
		for (int i = 0; i < 1410; i++) begin
			if (depth_guess < 3 || $urandom_range(0, 3) == 0) begin
				op = M_PUSH;
			end else if ($urandom_range(0, 40) == 0) begin
				op = 5'($urandom_range(18, 31));
			end else begin
				op = 5'($urandom_range(1, 17));
			end
			queue_cmd(op, rand_word());
			case (op)
				M_PUSH, M_DUP, M_OVER: depth_guess++;
				M_DOT, M_EMIT, M_DROP, M_ADD, M_SUB, M_MUL, M_DIV, M_REM, M_MOD,
				M_GT, M_LT, M_EQ, M_NEQ: depth_guess--;
				default: ;
			endcase
			if (depth_guess > 12)
				depth_guess = 12;
			if (depth_guess < 0)
				depth_guess = 0;
		end
		// last stretch runs with no idling on either side
		while (pending_cmds.size() > 150)
			@(posedge clk);
		quiet_tail = 1;
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sma_pkg.sv
rtl/sma_stack_mem.sv
rtl/sma_muldiv.sv
rtl/stack_machine_alu_top.sv
test/tb_top.sv
